@@ design/cbpa_pkg.sv @@
package cbpa_pkg;

  localparam int MAX_CHUNKS_DEF = 8;
  localparam int MAX_BLOCKS_DEF = 256;

  localparam logic [8:0] BPC_RESET = 9'd256;
  localparam int         USED_W    = 9;
  localparam logic [USED_W-1:0] USED_MAX = 9'd511;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OOM       = 2'd1;
  localparam logic [1:0] STATUS_BAD_CHUNK = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SHRINK = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] chunk_slot;
    logic [7:0] block_index;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] granted_chunk;
    logic [7:0] granted_block;
    logic [2:0] chunks_released;
    logic [3:0] chunks_in_use;
  } out_rsp_t;

  // Datapath commands, one per cycle, issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_ACCEPT,
    CMD_ALLOC_CHK,
    CMD_CREATE,
    CMD_POP,
    CMD_POP_DONE,
    CMD_FREE_WR,
    CMD_SHR_CHK,
    CMD_LOAD_OUT
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    op_t  cur_op;
    logic free_ok;
    logic hit;
    logic walk_last;
    logic pool_full;
    logic out_busy;
  } dp_status_t;

endpackage

@@ design/cbpa_ifs.sv @@
interface cbpa_in_if import cbpa_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cbpa_out_if import cbpa_pkg::*; ();
  logic     valid;
  logic     ready;
  out_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cbpa_cfg_if ();
  logic       valid;
  logic       ready;
  logic [8:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/chunked_block_pool_allocator.sv @@
// Allocate walks the active chunks newest first and is served by the first non-empty one;
// if all are empty a new chunk takes the lowest idle slot, else out of memory is reported.
// Free and other requests need no walk; shrink walks every active chunk. Each result waits
// while a previous result is still held. Throughput: one request at a time, the next is taken
// in the cycle the result shows; the chunk walk (order memory then per-slot flags) sets it.
// Reset (synchronous, active low) then a setup state; no clearing pass, a floor mark instead.
module chunked_block_pool_allocator import cbpa_pkg::*; #(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cbpa_in_if.sink    in_ch,
  cbpa_out_if.source out_ch,
  cbpa_cfg_if.sink   cfg_ch
);

  // The controller sequences each request as a string of single-cycle
  // commands; the controller holds only its state and ready registers, and
  // the datapath, owning the rest, reports back only through the status struct.
  cmd_t       cmd;
  dp_status_t dp_st;
  logic       in_ready;
  logic       in_accept;

  // The configuration register may be written at any time.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign in_accept    = in_ch.valid && in_ready;

  cbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .status    (dp_st),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  // Chunks are listed oldest first in a small order memory, so a new chunk
  // is appended and a shrink compacts the list in place while it walks it.
  // Allocation walks that list from the newest end: an order read, then a flag check, per chunk.
  cbpa_dpath #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_ch.payload),
    .cfg_wr    (cfg_ch.valid),
    .cfg_data  (cfg_ch.payload),
    .status    (dp_st),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rsp   (out_ch.payload)
  );

  // Only one request is in flight, so ready must drop straight after one is taken.
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ch.ready)
    else $error("request accepted while another was in flight");

  // Out of memory is only reported with every slot in use.
  a_oom_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.status == STATUS_OOM) |->
      (out_ch.payload.chunks_in_use == 4'(MAX_CHUNKS)))
    else $error("out of memory reported with a slot still idle");

  // A failed request carries no grant and releases nothing.
  a_failure_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.status != STATUS_OK) |->
      (out_ch.payload.granted_chunk == 3'd0 && out_ch.payload.granted_block == 8'd0 &&
       out_ch.payload.chunks_released == 3'd0))
    else $error("failed request carries grant or release data");

  // A chunk is only created while an idle slot exists.
  a_create_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_CREATE) |-> !dp_st.pool_full)
    else $error("chunk creation with every slot active");

endmodule

@@ design/cbpa_ram.sv @@
module cbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/cbpa_ctrl.sv @@
module cbpa_ctrl import cbpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  dp_status_t status,
  output cmd_t       cmd,
  output logic       in_ready
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ORD,
    S_ACHK,
    S_CREATE,
    S_POP,
    S_POPD,
    S_FWR,
    S_SCHK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd       = CMD_NONE;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd       = CMD_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) begin
          cmd = CMD_ACCEPT;
          case (status.in_op)
            OP_ALLOC:  state_nxt = S_ORD;
            OP_SHRINK: state_nxt = S_ORD;
            OP_FREE:   state_nxt = status.free_ok ? S_FWR : S_DONE;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_ORD: begin
        state_nxt = (status.cur_op == OP_SHRINK) ? S_SCHK : S_ACHK;
      end
      S_ACHK: begin
        cmd = CMD_ALLOC_CHK;
        if (status.hit) begin
          state_nxt = S_POP;
        end else if (status.walk_last) begin
          state_nxt = status.pool_full ? S_DONE : S_CREATE;
        end else begin
          state_nxt = S_ORD;
        end
      end
      S_CREATE: begin
        cmd       = CMD_CREATE;
        state_nxt = S_DONE;
      end
      S_POP: begin
        cmd       = CMD_POP;
        state_nxt = S_POPD;
      end
      S_POPD: begin
        cmd       = CMD_POP_DONE;
        state_nxt = S_DONE;
      end
      S_FWR: begin
        cmd       = CMD_FREE_WR;
        state_nxt = S_DONE;
      end
      S_SCHK: begin
        cmd       = CMD_SHR_CHK;
        state_nxt = status.walk_last ? S_DONE : S_ORD;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd       = CMD_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

@@ design/cbpa_dpath.sv @@
module cbpa_dpath import cbpa_pkg::*; #(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  in_req_t    in_req,
  input  logic       cfg_wr,
  input  logic [8:0] cfg_data,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output out_rsp_t   out_rsp
);

  localparam int SLOT_W    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
  localparam int POS_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int TOP_W     = $clog2(MAX_BLOCKS + 1);
  localparam int N_MAX     = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam int N_W       = $clog2(N_MAX + 1);
  localparam int ST_W      = TOP_W + USED_W + N_W;
  localparam int STK_AW    = SLOT_W + POS_W;
  localparam int STK_DEPTH = 1 << STK_AW;

  // Per-slot word: stack top, blocks in use, and the untouched-floor mark.
  // Stack positions below the mark are read as their own index, never from
  // the stack memory, so they never need to be written at creation.
  typedef struct packed {
    logic [TOP_W-1:0]  top;
    logic [USED_W-1:0] used;
    logic [N_W-1:0]    mark;
  } slot_state_t;

  logic [8:0]            bpc_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [MAX_CHUNKS-1:0] active_r;
  logic [MAX_CHUNKS-1:0] nonempty_r;
  logic [MAX_CHUNKS-1:0] used_zero_r;
  logic                  out_valid_r;
  out_rsp_t              out_rsp_r;

  op_t               op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [7:0]        blk_r;
  logic [SLOT_W-1:0] idx_r;
  logic [CNT_W-1:0]  kept_r;
  logic [SLOT_W-1:0] found_r;
  logic [SLOT_W-1:0] rel_r;
  logic [TOP_W-1:0]  t_r;
  logic              ident_r;
  logic [1:0]        res_status_r;
  logic [2:0]        res_gc_r;
  logic [7:0]        res_gb_r;

  logic [N_W-1:0]      n_eff;
  logic [SLOT_W+2:0]   in_slot_wide;
  logic [SLOT_W-1:0]   in_slot;
  logic                free_ok;
  logic [CNT_W-1:0]    cnt_m1;
  logic                newest;
  logic                pool_full;
  logic [SLOT_W-1:0]   idle_slot;
  logic                shr_drop;

  logic [SLOT_W-1:0]   ord_rdata;
  logic                ord_we;
  logic [SLOT_W-1:0]   ord_waddr;
  logic [SLOT_W-1:0]   ord_wdata;

  logic [ST_W-1:0]     st_rdata;
  slot_state_t         st_rd;
  logic                st_we;
  logic [SLOT_W-1:0]   st_waddr;
  logic [SLOT_W-1:0]   st_raddr;
  slot_state_t         st_wdata;

  logic [7:0]          stk_rdata;
  logic                stk_we;
  logic [STK_AW-1:0]   stk_waddr;
  logic [STK_AW-1:0]   stk_raddr;

  logic [TOP_W-1:0]    pop_t;
  logic                pop_ident;
  logic [USED_W-1:0]   used_inc;
  logic                can_push;
  logic [TOP_W-1:0]    push_top;
  logic [N_W-1:0]      push_mark;
  logic [USED_W-1:0]   used_dec;

  function automatic logic [SLOT_W-1:0] lowest_idle(input logic [MAX_CHUNKS-1:0] act);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (!act[i]) begin
        s = SLOT_W'(i);
      end
    end
    return s;
  endfunction

  // Block count actually carved into a new chunk.
  always_comb begin
    if (bpc_r == 9'd0) begin
      n_eff = N_W'(1);
    end else if (32'(bpc_r) > N_MAX) begin
      n_eff = N_W'(N_MAX);
    end else begin
      n_eff = N_W'(bpc_r);
    end
  end

  assign in_slot_wide = {{SLOT_W{1'b0}}, in_req.chunk_slot};
  assign in_slot      = in_slot_wide[SLOT_W-1:0];
  assign free_ok      = (32'(in_req.chunk_slot) < MAX_CHUNKS) && active_r[in_slot];
  assign cnt_m1       = cnt_r - CNT_W'(1);
  assign newest       = (CNT_W'(idx_r) == cnt_m1);
  assign pool_full    = (cnt_r == CNT_W'(MAX_CHUNKS));
  assign idle_slot    = lowest_idle(active_r);
  assign shr_drop     = !newest && used_zero_r[ord_rdata];

  assign status.in_op     = op_t'(in_req.operation);
  assign status.cur_op    = op_r;
  assign status.free_ok   = free_ok;
  assign status.hit       = nonempty_r[ord_rdata];
  assign status.walk_last = (op_r == OP_SHRINK) ? newest : (idx_r == '0);
  assign status.pool_full = pool_full;
  assign status.out_busy  = out_valid_r && !out_ready;

  assign st_rd = slot_state_t'(st_rdata);

  // Pop arithmetic.
  assign pop_t     = st_rd.top - TOP_W'(1);
  assign pop_ident = pop_t < TOP_W'(st_rd.mark);
  assign used_inc  = (st_rd.used == USED_MAX) ? st_rd.used : st_rd.used + USED_W'(1);

  // Push arithmetic; a push onto a full stack is dropped.
  assign can_push  = st_rd.top < TOP_W'(MAX_BLOCKS);
  assign push_top  = can_push ? st_rd.top + TOP_W'(1) : st_rd.top;
  assign push_mark = (can_push && (TOP_W'(st_rd.mark) > st_rd.top)) ?
                     N_W'(st_rd.top) : st_rd.mark;
  assign used_dec  = (st_rd.used == '0) ? st_rd.used : st_rd.used - USED_W'(1);

  // Age-ordered list of active slots, oldest at entry 0.
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = kept_r[SLOT_W-1:0];
    ord_wdata = ord_rdata;
    case (cmd)
      CMD_INIT: begin
        ord_we    = 1'b1;
        ord_waddr = '0;
        ord_wdata = '0;
      end
      CMD_CREATE: begin
        ord_we    = 1'b1;
        ord_waddr = cnt_r[SLOT_W-1:0];
        ord_wdata = idle_slot;
      end
      CMD_SHR_CHK: begin
        ord_we = !shr_drop;
      end
      default: begin
        ord_we = 1'b0;
      end
    endcase
  end

  // Per-slot state memory.
  assign st_raddr = (cmd == CMD_ACCEPT) ? in_slot : ord_rdata;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = found_r;
    st_wdata = st_rd;
    case (cmd)
      CMD_INIT: begin
        st_we    = 1'b1;
        st_waddr = '0;
        st_wdata = '{top: TOP_W'(n_eff), used: '0, mark: n_eff};
      end
      CMD_CREATE: begin
        st_we    = 1'b1;
        st_waddr = idle_slot;
        st_wdata = '{top: TOP_W'(n_eff - N_W'(1)), used: USED_W'(1), mark: n_eff};
      end
      CMD_POP: begin
        st_we    = 1'b1;
        st_waddr = found_r;
        st_wdata = '{top: pop_t, used: used_inc, mark: st_rd.mark};
      end
      CMD_FREE_WR: begin
        st_we    = 1'b1;
        st_waddr = slot_r;
        st_wdata = '{top: push_top, used: used_dec, mark: push_mark};
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  // Free stacks of all chunks, one region per slot.
  assign stk_raddr = {found_r, pop_t[POS_W-1:0]};
  assign stk_we    = (cmd == CMD_FREE_WR) && can_push;
  assign stk_waddr = {slot_r, st_rd.top[POS_W-1:0]};

  cbpa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_CHUNKS)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (idx_r),
    .rdata (ord_rdata)
  );

  cbpa_ram #(.WIDTH(ST_W), .DEPTH(MAX_CHUNKS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  cbpa_ram #(.WIDTH(8), .DEPTH(STK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (blk_r),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r       <= BPC_RESET;
      cnt_r       <= CNT_W'(1);
      active_r    <= MAX_CHUNKS'(1);
      nonempty_r  <= MAX_CHUNKS'(1);
      used_zero_r <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        bpc_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_CREATE: begin
          active_r[idle_slot]    <= 1'b1;
          nonempty_r[idle_slot]  <= (n_eff != N_W'(1));
          used_zero_r[idle_slot] <= 1'b0;
          cnt_r                  <= cnt_r + CNT_W'(1);
        end
        CMD_POP: begin
          nonempty_r[found_r]  <= (pop_t != '0);
          used_zero_r[found_r] <= 1'b0;
        end
        CMD_FREE_WR: begin
          nonempty_r[slot_r]  <= 1'b1;
          used_zero_r[slot_r] <= (used_dec == '0);
        end
        CMD_SHR_CHK: begin
          if (shr_drop) begin
            active_r[ord_rdata]   <= 1'b0;
            nonempty_r[ord_rdata] <= 1'b0;
          end
          if (newest) begin
            cnt_r <= kept_r + CNT_W'(1);
          end
        end
        CMD_LOAD_OUT: begin
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Operation payload and result fields.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_ACCEPT: begin
        op_r     <= op_t'(in_req.operation);
        slot_r   <= in_slot;
        blk_r    <= in_req.block_index;
        idx_r    <= (op_t'(in_req.operation) == OP_SHRINK) ? '0 : cnt_m1[SLOT_W-1:0];
        kept_r   <= '0;
        rel_r    <= '0;
        res_gc_r <= '0;
        res_gb_r <= '0;
        res_status_r <= (op_t'(in_req.operation) == OP_FREE && !free_ok) ?
                        STATUS_BAD_CHUNK : STATUS_OK;
      end
      CMD_ALLOC_CHK: begin
        if (nonempty_r[ord_rdata]) begin
          found_r <= ord_rdata;
        end else if (idx_r == '0) begin
          if (pool_full) begin
            res_status_r <= STATUS_OOM;
          end
        end else begin
          idx_r <= idx_r - SLOT_W'(1);
        end
      end
      CMD_CREATE: begin
        res_gc_r <= 3'(idle_slot);
        res_gb_r <= 8'(n_eff - N_W'(1));
      end
      CMD_POP: begin
        t_r      <= pop_t;
        ident_r  <= pop_ident;
        res_gc_r <= 3'(found_r);
      end
      CMD_POP_DONE: begin
        res_gb_r <= ident_r ? 8'(t_r) : stk_rdata;
      end
      CMD_SHR_CHK: begin
        if (shr_drop) begin
          rel_r <= rel_r + SLOT_W'(1);
        end else begin
          kept_r <= kept_r + CNT_W'(1);
        end
        if (!newest) begin
          idx_r <= idx_r + SLOT_W'(1);
        end
      end
      CMD_LOAD_OUT: begin
        out_rsp_r.status          <= res_status_r;
        out_rsp_r.granted_chunk   <= res_gc_r;
        out_rsp_r.granted_block   <= res_gb_r;
        out_rsp_r.chunks_released <= 3'(rel_r);
        out_rsp_r.chunks_in_use   <= 4'(cnt_r);
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import cbpa_pkg::*;

  // A block reference as handed out by an allocate request.
  typedef struct packed {
    logic [2:0] slot;
    logic [7:0] blk;
  } block_ref_t;

  // One row of the directed stimulus. Where typed is set, want holds the result
  // that can be read straight off the behaviour; otherwise the pool model decides.
  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  cbpa_in_if  in_if ();
  cbpa_out_if out_if ();
  cbpa_cfg_if cfg_if ();

  chunked_block_pool_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Pool model state: our own copy of every chunk's stack, counts and ordering.
  logic [8:0]  pool_bpc;
  bit          pool_live [MAX_CHUNKS_DEF];
  int unsigned pool_order [MAX_CHUNKS_DEF];
  int unsigned pool_used [MAX_CHUNKS_DEF];
  int unsigned pool_top [MAX_CHUNKS_DEF];
  logic [7:0]  pool_stack [MAX_CHUNKS_DEF][MAX_BLOCKS_DEF];
  int unsigned pool_active_n;

  // Results still owed by the block, oldest first, and blocks currently handed out.
  out_rsp_t    pending_results[$];
  block_ref_t  held_blocks[$];
  dir_row_t    dir_rows[$];

  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned burst_left = 0;

  // The clock runs with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // The run is cut off well beyond the slowest legal run of the stimulus.
  initial begin
    #5000000;
    $display("chunked_block_pool_allocator verification failed");
    $finish;
  end

  // Number of blocks carved into a new chunk: zero counts as one, and the value
  // is clamped to the pool's block capacity.
  function automatic int unsigned chunk_size();
    int unsigned n;
    n = pool_bpc;
    if (n == 0) n = 1;
    if (n > 256) n = 256;
    if (n > MAX_BLOCKS_DEF) n = MAX_BLOCKS_DEF;
    return n;
  endfunction

  // Fill slot s with blocks 0..N-1 and make it the newest chunk.
  function automatic void create_chunk(int unsigned s);
    int unsigned n;
    n = chunk_size();
    for (int i = 0; i < n; i++) pool_stack[s][i] = i[7:0];
    pool_top[s]  = n;
    pool_used[s] = 0;
    pool_live[s] = 1'b1;
    for (int i = pool_active_n; i > 0; i--) pool_order[i] = pool_order[i-1];
    pool_order[0] = s;
    pool_active_n++;
  endfunction

  function automatic void reset_pool();
    pool_bpc = BPC_RESET;
    for (int c = 0; c < MAX_CHUNKS_DEF; c++) begin
      pool_live[c]  = 1'b0;
      pool_order[c] = 0;
      pool_used[c]  = 0;
      pool_top[c]   = 0;
      for (int b = 0; b < MAX_BLOCKS_DEF; b++) pool_stack[c][b] = 8'd0;
    end
    pool_active_n = 0;
    create_chunk(0);
  endfunction

  // Applies one request to the pool model and returns the result it must produce.
  function automatic out_rsp_t next_pool_result(in_req_t r);
    out_rsp_t    res;
    bit          found;
    int unsigned s;
    int unsigned c;
    int unsigned kept;
    int unsigned rel;
    res   = '0;
    found = 1'b0;
    s     = 0;
    kept  = 0;
    rel   = 0;
    case (r.operation)
      OP_ALLOC: begin
        // Newest chunk with a free block wins.
        for (int i = 0; i < pool_active_n && !found; i++) begin
          if (pool_top[pool_order[i]] > 0) begin
            s = pool_order[i];
            found = 1'b1;
          end
        end
        // Otherwise open a new chunk in the lowest idle slot, if one is left.
        if (!found) begin
          for (int i = 0; i < MAX_CHUNKS_DEF && !found; i++) begin
            if (!pool_live[i]) begin
              s = i;
              found = 1'b1;
            end
          end
          if (found) create_chunk(s);
        end
        if (!found) begin
          res.status = STATUS_OOM;
        end else begin
          pool_top[s]--;
          res.granted_block = pool_stack[s][pool_top[s]];
          res.granted_chunk = s[2:0];
          if (pool_used[s] < USED_MAX) pool_used[s]++;
        end
      end
      OP_FREE: begin
        s = r.chunk_slot;
        if (!pool_live[s]) begin
          res.status = STATUS_BAD_CHUNK;
        end else begin
          // A double free is not caught; a push onto a full stack is lost.
          if (pool_top[s] < MAX_BLOCKS_DEF) begin
            pool_stack[s][pool_top[s]] = r.block_index;
            pool_top[s]++;
          end
          if (pool_used[s] > 0) pool_used[s]--;
        end
      end
      OP_SHRINK: begin
        // Every empty chunk but the newest is released.
        for (int i = 0; i < pool_active_n; i++) begin
          c = pool_order[i];
          if (i != 0 && pool_used[c] == 0) begin
            pool_live[c] = 1'b0;
            pool_top[c]  = 0;
            rel++;
          end else begin
            pool_order[kept] = c;
            kept++;
          end
        end
        pool_active_n = kept;
        res.chunks_released = rel[2:0];
      end
      default: begin
      end
    endcase
    res.chunks_in_use = pool_active_n[3:0];
    return res;
  endfunction

  function automatic out_rsp_t rsp(logic [1:0] st, logic [2:0] gc, logic [7:0] gb,
                                   logic [2:0] rel, logic [3:0] inuse);
    out_rsp_t r;
    r.status          = st;
    r.granted_chunk   = gc;
    r.granted_block   = gb;
    r.chunks_released = rel;
    r.chunks_in_use   = inuse;
    return r;
  endfunction

  function automatic in_req_t make_req(logic [1:0] op, logic [2:0] slot, logic [7:0] blk);
    in_req_t r;
    r.operation   = op;
    r.chunk_slot  = slot;
    r.block_index = blk;
    return r;
  endfunction

  task automatic add_row(logic [1:0] op, logic [2:0] slot, logic [7:0] blk,
                         bit typed, out_rsp_t want);
    dir_row_t row;
    row.req   = make_req(op, slot, blk);
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Offers one request and holds it until the block takes it. The sender works in
  // bursts: between bursts valid drops for a random pause. Once accepted, the request
  // goes through the pool model and its result joins the queue of owed results.
  // The receiver watches the count of requests sent and holds off once for a long
  // stretch, so that the block backs up while the sender keeps offering requests.
  task automatic send_request(in_req_t r, bit typed, out_rsp_t want);
    out_rsp_t   got;
    block_ref_t ref_blk;
    in_if.valid   <= 1'b1;
    in_if.payload <= r;
    do @(posedge clk); while (!in_if.ready);
    got = next_pool_result(r);
    pending_results.push_back(typed ? want : got);
    if (r.operation == OP_ALLOC && got.status == STATUS_OK) begin
      ref_blk.slot = got.granted_chunk;
      ref_blk.blk  = got.granted_block;
      held_blocks.push_back(ref_blk);
    end
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  // The sender stands still until every owed result has come back.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The register is only written while the block has nothing in flight.
  task automatic write_blocks_per_chunk(logic [8:0] v);
    wait_idle();
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    pool_bpc = v;
  endtask

  // One phase of random traffic. Most frees return a block that really is held,
  // so that chunks empty out and shrink has work to do; the remainder is noise:
  // unused operations, frees of arbitrary slots and indices, double frees.
  task automatic run_phase(logic [8:0] bpc, int unsigned items,
                           int unsigned pa, int unsigned pf, int unsigned ps);
    int unsigned roll;
    int unsigned k;
    block_ref_t  pick;
    in_req_t     req;
    write_blocks_per_chunk(bpc);
    repeat (items) begin
      roll = $urandom_range(0, 99);
      if (roll < pa) begin
        req = make_req(OP_ALLOC, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else if (roll < pa + pf && held_blocks.size() > 0) begin
        k    = $urandom_range(0, held_blocks.size() - 1);
        pick = held_blocks[k];
        held_blocks.delete(k);
        req = make_req(OP_FREE, pick.slot, pick.blk);
      end else if (roll < pa + pf + ps) begin
        req = make_req(OP_SHRINK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else begin
        req = make_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 255)));
      end
      send_request(req, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Every accepted result is held against the oldest owed one, field by field.
  always @(posedge clk) begin : result_check
    out_rsp_t want;
    out_rsp_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 8'(want.status), 8'(got.status));
        check_field("granted_chunk", 8'(want.granted_chunk), 8'(got.granted_chunk));
        check_field("granted_block", want.granted_block, got.granted_block);
        check_field("chunks_released", 8'(want.chunks_released), 8'(got.chunks_released));
        check_field("chunks_in_use", 8'(want.chunks_in_use), 8'(got.chunks_in_use));
      end
    end
  end

  // The receiver cycles through stall patterns of its own: always ready, coin
  // tosses, a repeating bit pattern and mostly-ready. Once 120 requests have been
  // sent, a single long hold-off overrides the pattern.
  initial begin : result_sink
    int unsigned hold_cnt;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned step;
    logic [15:0] pat;
    bit          hold_done;
    hold_cnt     = 0;
    mode         = 0;
    mode_left    = 0;
    step         = 0;
    pat          = '1;
    hold_done    = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && sent_count >= 120) begin
        hold_done     = 1'b1;
        hold_cnt      = 300;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
          pat       = 16'($urandom);
        end
        mode_left--;
        step++;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= pat[step % 16];
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned waited;
    int unsigned pa;
    int unsigned pf;
    logic [8:0]  bpc;
    // Every input of the block starts at a known value, reset held low.
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    reset_pool();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, from the reset state with one full chunk of 256 blocks in
    // slot 0. Results that are plain from the reset state are typed in.
    add_row(OP_ALLOC,  3'd0, 8'd0,   1'b1, rsp(STATUS_OK, 3'd0, 8'd255, 3'd0, 4'd1));
    add_row(OP_ALLOC,  3'd7, 8'd255, 1'b1, rsp(STATUS_OK, 3'd0, 8'd254, 3'd0, 4'd1));
    add_row(OP_FREE,   3'd0, 8'd255, 1'b1, rsp(STATUS_OK, 3'd0, 8'd0,   3'd0, 4'd1));
    // Last in, first out: the block just returned comes straight back.
    add_row(OP_ALLOC,  3'd0, 8'd0,   1'b1, rsp(STATUS_OK, 3'd0, 8'd255, 3'd0, 4'd1));
    // Frees naming an idle slot are refused.
    add_row(OP_FREE,   3'd7, 8'd0,   1'b1, rsp(STATUS_BAD_CHUNK, 3'd0, 8'd0, 3'd0, 4'd1));
    add_row(OP_FREE,   3'd1, 8'd255, 1'b1, rsp(STATUS_BAD_CHUNK, 3'd0, 8'd0, 3'd0, 4'd1));
    // Shrink with only the newest chunk alive releases nothing.
    add_row(OP_SHRINK, 3'd0, 8'd0,   1'b1, rsp(STATUS_OK, 3'd0, 8'd0, 3'd0, 4'd1));
    // The unused operation code does nothing.
    add_row(OP_NONE,   3'd7, 8'd255, 1'b1, rsp(STATUS_OK, 3'd0, 8'd0, 3'd0, 4'd1));
    // Double free of a block never handed out, then a free onto a full stack.
    add_row(OP_FREE,   3'd0, 8'd0,   1'b0, '0);
    add_row(OP_FREE,   3'd0, 8'd255, 1'b0, '0);
    add_row(OP_FREE,   3'd0, 8'd254, 1'b0, '0);
    add_row(OP_ALLOC,  3'd0, 8'd0,   1'b0, '0);
    add_row(OP_ALLOC,  3'd5, 8'd85,  1'b0, '0);
    add_row(OP_ALLOC,  3'd2, 8'd170, 1'b0, '0);
    add_row(OP_FREE,   3'd0, 8'd128, 1'b0, '0);
    add_row(OP_FREE,   3'd3, 8'd85,  1'b1, rsp(STATUS_BAD_CHUNK, 3'd0, 8'd0, 3'd0, 4'd1));
    add_row(OP_FREE,   3'd4, 8'd170, 1'b1, rsp(STATUS_BAD_CHUNK, 3'd0, 8'd0, 3'd0, 4'd1));
    add_row(OP_NONE,   3'd2, 8'd0,   1'b1, rsp(STATUS_OK, 3'd0, 8'd0, 3'd0, 4'd1));
    add_row(OP_SHRINK, 3'd7, 8'd255, 1'b1, rsp(STATUS_OK, 3'd0, 8'd0, 3'd0, 4'd1));
    add_row(OP_ALLOC,  3'd1, 8'd1,   1'b0, '0);
    add_row(OP_FREE,   3'd6, 8'd1,   1'b1, rsp(STATUS_BAD_CHUNK, 3'd0, 8'd0, 3'd0, 4'd1));
    add_row(OP_FREE,   3'd5, 8'd254, 1'b1, rsp(STATUS_BAD_CHUNK, 3'd0, 8'd0, 3'd0, 4'd1));
    add_row(OP_ALLOC,  3'd0, 8'd0,   1'b0, '0);
    // Index 0 pushed as given into slot 0.
    add_row(OP_FREE,   3'd0, 8'd0,   1'b0, '0);
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Random part. The first phase is allocate-heavy with tiny chunks, so slot 0
    // runs dry, every slot fills and out-of-memory is reached. Later phases drain,
    // shrink and refill with the register at its extremes and between them.
    run_phase(9'd3,   330, 95, 3,  1);
    run_phase(9'd0,   90,  25, 60, 12);
    run_phase(9'd511, 60,  50, 40, 8);
    run_phase(9'd1,   100, 70, 20, 8);
    run_phase(9'd256, 60,  30, 55, 12);
    repeat (5) begin
      bpc = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(1, 6)) :
                                           9'($urandom_range(0, 511));
      pa  = $urandom_range(20, 75);
      pf  = $urandom_range(10, 95 - pa);
      run_phase(bpc, 40, pa, pf, $urandom_range(2, 10));
    end

    // Wait for the last results, with a limit, then keep watching so that a
    // stray extra result would still be caught.
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("chunked_block_pool_allocator verification clean");
    end else begin
      $display("chunked_block_pool_allocator verification failed");
    end
    $finish;
  end

endmodule

@@ chunked_block_pool_allocator.f @@
design/cbpa_pkg.sv
design/cbpa_ifs.sv
design/cbpa_ram.sv
design/cbpa_ctrl.sv
design/cbpa_dpath.sv
design/chunked_block_pool_allocator.sv
tb/sv/tb_top.sv
